// File: rtl/aoc_pkg.sv
// ----------------------------------------------------------------------------
// aoc_pkg
// Types and constants shared by the source-over compositing pipeline.
// ----------------------------------------------------------------------------
package aoc_pkg;

  localparam int unsigned PixW   = 32;
  localparam int unsigned CfgW   = 17;
  localparam int unsigned NumW   = 26;
  localparam int unsigned DenW   = 17;
  localparam int unsigned NumCh  = 3;
  localparam int unsigned QBits  = 8;

  typedef enum logic [1:0] {
    CFG_REMAP_EN = 2'd0,
    CFG_LOW      = 2'd1,
    CFG_HIGH     = 2'd2
  } cfg_reg_e;

  // remapped source and destination, with the trivial cases resolved
  typedef struct packed {
    logic            bypass;
    logic [PixW-1:0] pix;
    logic [PixW-1:0] src;
    logic [PixW-1:0] dst;
  } blend_t;

  // one item inside the divider
  typedef struct packed {
    logic                         bypass;
    logic [PixW-1:0]              pix;
    logic [DenW-1:0]              den;
    logic [NumCh-1:0][NumW-1:0]   rem;
    logic [NumCh-1:0][QBits-1:0]  quo;
  } div_t;

endpackage

// File: rtl/aoc_remap.sv
// ----------------------------------------------------------------------------
// aoc_remap
// Two stages: alpha remap products, then sum, saturation and case selection.
// ----------------------------------------------------------------------------
module aoc_remap (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [31:0]            dest_pixel_i,
  input  logic [31:0]            src_pixel_i,
  input  logic                   remap_en_i,
  input  logic [16:0]            alpha_low_i,
  input  logic [16:0]            alpha_high_i,
  output logic                   valid_o,
  output aoc_pkg::blend_t        blend_o
);
  import aoc_pkg::*;

  logic [7:0]  a_in, a_inv;
  logic        v1_q, v2_q;
  logic        ren_q;
  logic [31:0] src1_q, dst1_q;
  logic [24:0] prod_lo_d, prod_hi_d, prod_lo_q, prod_hi_q;
  logic [25:0] sum;
  logic [9:0]  scaled;
  logic [7:0]  alpha;
  logic [31:0] src_rm;
  blend_t      blend_d, blend_q;

  assign a_in      = src_pixel_i[31:24];
  assign a_inv     = 8'd255 - a_in;
  assign prod_lo_d = 25'(a_inv) * 25'(alpha_low_i);
  assign prod_hi_d = 25'(a_in) * 25'(alpha_high_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ren_q     <= remap_en_i;
      src1_q    <= src_pixel_i;
      dst1_q    <= dest_pixel_i;
      prod_lo_q <= prod_lo_d;
      prod_hi_q <= prod_hi_d;
      blend_q   <= blend_d;
    end
  end

  always_comb begin
    sum    = {1'b0, prod_lo_q} + {1'b0, prod_hi_q};
    scaled = sum[25:16];
    if (!ren_q)             alpha = src1_q[31:24];
    else if (|scaled[9:8])  alpha = 8'hff;
    else                    alpha = scaled[7:0];
    src_rm = {alpha, src1_q[23:0]};

    blend_d.src    = src_rm;
    blend_d.dst    = dst1_q;
    blend_d.bypass = 1'b1;
    if (alpha == 8'd0) begin
      blend_d.pix = dst1_q;
    end else if (alpha == 8'hff || dst1_q[31:24] == 8'd0) begin
      blend_d.pix = src_rm;
    end else begin
      blend_d.pix    = src_rm;
      blend_d.bypass = 1'b0;
    end
  end

  assign valid_o = v2_q;
  assign blend_o = blend_q;

endmodule

// File: rtl/aoc_prep.sv
// ----------------------------------------------------------------------------
// aoc_prep
// Two stages: channel products, then numerators and the common denominator.
// ----------------------------------------------------------------------------
module aoc_prep (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  aoc_pkg::blend_t blend_i,
  output logic            valid_o,
  output aoc_pkg::div_t   div_o
);
  import aoc_pkg::*;

  logic                   v3_q, v4_q;
  logic                   byp_q;
  logic [PixW-1:0]        pix_q;
  logic [7:0]             as_q, ad_q;
  logic [15:0]            asad_q;
  logic [NumCh-1:0][15:0] csas_d, cdad_d, csas_q, cdad_q;
  logic [8:0]             as_inv;
  logic [8:0]             as_sum;
  div_t                   div_d, div_q;

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      csas_d[i] = 16'(blend_i.src[8*i +: 8]) * 16'(blend_i.src[31:24]);
      cdad_d[i] = 16'(blend_i.dst[8*i +: 8]) * 16'(blend_i.dst[31:24]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      byp_q  <= blend_i.bypass;
      pix_q  <= blend_i.pix;
      as_q   <= blend_i.src[31:24];
      ad_q   <= blend_i.dst[31:24];
      asad_q <= 16'(blend_i.src[31:24]) * 16'(blend_i.dst[31:24]);
      csas_q <= csas_d;
      cdad_q <= cdad_d;
      div_q  <= div_d;
    end
  end

  always_comb begin
    as_inv       = 9'd256 - {1'b0, as_q};
    as_sum       = {1'b0, as_q} + {1'b0, ad_q};
    div_d.bypass = byp_q;
    div_d.pix    = pix_q;
    div_d.den    = {as_sum, 8'd0} - {1'b0, asad_q};
    div_d.quo    = '0;
    for (int i = 0; i < NumCh; i++) begin
      div_d.rem[i] = {2'b00, csas_q[i], 8'd0} + NumW'(cdad_q[i]) * NumW'(as_inv);
    end
  end

  assign valid_o = v4_q;
  assign div_o   = div_q;

endmodule

// File: rtl/aoc_div.sv
// ----------------------------------------------------------------------------
// aoc_div
// Eight-stage restoring divider, one quotient bit per stage, three channels.
// ----------------------------------------------------------------------------
module aoc_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  aoc_pkg::div_t div_i,
  output logic          valid_o,
  output aoc_pkg::div_t div_o
);
  import aoc_pkg::*;

  logic [QBits:0] vld;
  div_t           st [QBits+1];

  assign vld[0] = valid_i;
  assign st[0]  = div_i;

  for (genvar g = 0; g < QBits; g++) begin : g_step
    localparam int unsigned Bit = QBits - 1 - g;
    logic [NumW-1:0] trial;
    logic            v_q;
    div_t            s_d, s_q;

    assign trial = NumW'(st[g].den) << Bit;

    always_comb begin
      s_d = st[g];
      for (int i = 0; i < NumCh; i++) begin
        if (st[g].rem[i] >= trial) begin
          s_d.rem[i]      = st[g].rem[i] - trial;
          s_d.quo[i][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q <= 1'b0;
      else if (en_i) v_q <= vld[g];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) s_q <= s_d;
    end

    assign vld[g+1] = v_q;
    assign st[g+1]  = s_q;
  end

  assign valid_o = vld[QBits];
  assign div_o   = st[QBits];

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !div_o.bypass |-> div_o.rem[0] < NumW'(div_o.den)
      && div_o.rem[1] < NumW'(div_o.den) && div_o.rem[2] < NumW'(div_o.den))
    else $error("divider remainder not below denominator");
  a_alpha_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !div_o.bypass |-> div_o.den[15:8] != 8'd0)
    else $error("blended alpha is zero");
`endif

endmodule

// File: rtl/argb_over_composite.sv
// ----------------------------------------------------------------------------
// argb_over_composite
// Source-over compositing of packed 8-bit ARGB pixel pairs, optional alpha
// remap of the source.
// ----------------------------------------------------------------------------
// One pixel pair is taken per cycle while in_ready_o is high, and its result is
// offered through 12 register stages: the alpha remap and product stages (4)
// and the divider, which resolves one quotient bit per stage (8).
// The whole pipeline holds while a finished result waits on out_ready_i.
// Registers are written through the cfg channel, which is always ready; the user
// must write them only while idle, as the block itself does not enforce it.
module argb_over_composite (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] dest_pixel_i,
  input  logic [31:0] src_pixel_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_pixel_o
);
  import aoc_pkg::*;

  logic            en;
  logic            remap_en_q;
  logic [CfgW-1:0] alpha_low_q, alpha_high_q;
  logic            rm_valid, pr_valid, dv_valid;
  blend_t          rm_blend;
  div_t            pr_div, dv_div;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remap_en_q   <= 1'b0;
      alpha_low_q  <= '0;
      alpha_high_q <= CfgW'(65536);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_REMAP_EN: remap_en_q   <= cfg_data_i[0];
        CFG_LOW:      alpha_low_q  <= cfg_data_i[CfgW-1:0];
        CFG_HIGH:     alpha_high_q <= cfg_data_i[CfgW-1:0];
        default: ;
      endcase
    end
  end

  assign en         = !dv_valid || out_ready_i;
  assign in_ready_o = en;

  aoc_remap u_remap (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_i),
    .dest_pixel_i (dest_pixel_i),
    .src_pixel_i  (src_pixel_i),
    .remap_en_i   (remap_en_q),
    .alpha_low_i  (alpha_low_q),
    .alpha_high_i (alpha_high_q),
    .valid_o      (rm_valid),
    .blend_o      (rm_blend)
  );

  aoc_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rm_valid),
    .blend_i (rm_blend),
    .valid_o (pr_valid),
    .div_o   (pr_div)
  );

  aoc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pr_valid),
    .div_i   (pr_div),
    .valid_o (dv_valid),
    .div_o   (dv_div)
  );

  assign out_valid_o = dv_valid;
  assign out_pixel_o = dv_div.bypass ? dv_div.pix
                     : {dv_div.den[15:8], dv_div.quo[2], dv_div.quo[1], dv_div.quo[0]};

`ifndef SYNTHESIS
  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");
  a_result_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(dv_div))
    else $error("pending result changed during stall");
  a_prep_feeds_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pr_valid && in_ready_o |=> u_div.g_step[0].v_q)
    else $error("item lost between prep and divider");
`endif

endmodule

// File: verif/argb_over_composite_tb.sv
// ----------------------------------------------------------------------------
// argb_over_composite_tb
// Drives pixel pairs through the source-over compositor under several alpha
// remap settings with random sender/receiver idling, predicts each composite
// pixel in-bench and compares it with the block's output in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module argb_over_composite_tb;
  import aoc_pkg::*;

  localparam int unsigned Latency = 12;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] dest_pixel_i = '0;
  logic [31:0] src_pixel_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] out_pixel_o;

  argb_over_composite dut (.*);

  always #1 clk_i = ~clk_i;

  logic        remap_en_q = 1'b0;
  logic [16:0] alpha_low_q = '0;
  logic [16:0] alpha_high_q = 17'd65536;
  logic [31:0] pixels_due[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_cycles = 0;
  int          fail_cnt = 0;

  function automatic logic [7:0] remapped_alpha(logic [7:0] a);
    logic [63:0] num;
    num = 64'(255 - a) * alpha_low_q + 64'(a) * alpha_high_q;
    num = num >> 16;
    return (num > 255) ? 8'd255 : num[7:0];
  endfunction

  function automatic logic [31:0] composite_pixel(logic [31:0] dst, logic [31:0] src);
    logic [7:0]  as, ad;
    logic [63:0] den, num;
    logic [31:0] res;
    if (remap_en_q) src[31:24] = remapped_alpha(src[31:24]);
    as = src[31:24];
    ad = dst[31:24];
    if (as == 0) return dst;
    if (as == 255 || ad == 0) return src;
    den = 256 * (64'(as) + ad) - 64'(as) * ad;
    for (int c = 0; c < 3; c++) begin
      num = 256 * 64'(src[8*c +: 8]) * as + 64'(dst[8*c +: 8]) * ad * (256 - as);
      res[8*c +: 8] = 8'(num / den);
    end
    res[31:24] = 8'(den >> 8);
    return res;
  endfunction

  // receiver: random stall, plus long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixels_due.size() == 0) begin
        $error("out_pixel: unexpected transfer, actual %h", out_pixel_o);
        fail_cnt++;
      end else begin
        if (out_pixel_o !== pixels_due[0]) begin
          $error("out_pixel: expected %h actual %h", pixels_due[0], out_pixel_o);
          fail_cnt++;
        end
        void'(pixels_due.pop_front());
      end
    end
  end

  task automatic send_pair(logic [31:0] dst, logic [31:0] src);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    dest_pixel_i <= dst;
    src_pixel_i  <= src;
    do @(posedge clk_i); while (!in_ready_o);
    pixels_due = {pixels_due, composite_pixel(dst, src)};
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_REMAP_EN: remap_en_q   = data[0];
      CFG_LOW:      alpha_low_q  = data[16:0];
      default:      alpha_high_q = data[16:0];
    endcase
  endtask

  task automatic set_remap(logic en, logic [16:0] lo, logic [16:0] hi);
    drain();
    write_reg(CFG_REMAP_EN, 32'(en));
    write_reg(CFG_LOW, 32'(lo));
    write_reg(CFG_HIGH, 32'(hi));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] rand_alpha();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'hffff_ffff, 32'hffff_ffff);
    send_pair(32'h8012_3456, 32'h00ab_cdef);
    send_pair(32'h8012_3456, 32'hffab_cdef);
    send_pair(32'h0012_3456, 32'h40ab_cdef);
    send_pair(32'h01ff_ffff, 32'h0100_0000);
    send_pair(32'hfe00_0000, 32'hfeff_ffff);
    send_pair(32'h7fff_00ff, 32'h80ff_ff00);
    send_pair(32'haa55_aa55, 32'h55aa_55aa);
    send_pair(32'h0155_aa55, 32'hfeaa_55aa);
  endtask

  task automatic test_random(int n);
    logic [31:0] d, s;
    repeat (n) begin
      d = $urandom;
      s = $urandom;
      d[31:24] = rand_alpha();
      s[31:24] = rand_alpha();
      send_pair(d, s);
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 60;
    repeat (40) test_random(1);
  endtask

  task automatic test_remap_sweep();
    set_remap(1'b1, 17'd0, 17'd65536);
    test_directed();
    test_random(80);
    set_remap(1'b1, 17'd65536, 17'd0);
    test_random(80);
    set_remap(1'b1, 17'h1ffff, 17'h1ffff);
    test_random(40);
    set_remap(1'b1, 17'd0, 17'd0);
    test_random(40);
    set_remap(1'b1, 17'($urandom), 17'($urandom));
    test_random(80);
    set_remap(1'b1, 17'd12000, 17'd50000);
    test_random(80);
    set_remap(1'b0, 17'h1ffff, 17'd0);
    test_random(40);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 37;
    recv_idle_pct = 81;
    test_directed();
    test_random(175);
    send_idle_pct = 81;
    recv_idle_pct = 37;
    test_random(175);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_remap_sweep();
    drain();
    if (fail_cnt == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
